FILE: design/md4_pkg.sv
package md4_pkg;

	typedef logic [31:0] word_t;

	localparam word_t IV_A = 32'h67452301;
	localparam word_t IV_B = 32'hefcdab89;
	localparam word_t IV_C = 32'h98badcfe;
	localparam word_t IV_D = 32'h10325476;

	localparam int STEPS = 48;
	localparam logic [5:0] LAST_STEP = 6'(STEPS - 1);

	// message word used by a step: straight, transposed, bit-reversed
	function automatic logic [3:0] msg_idx(input logic [5:0] step);
		logic [3:0] idx;
		case (step[5:4])
			2'd0:    idx = step[3:0];
			2'd1:    idx = {step[1:0], step[3:2]};
			default: idx = {step[0], step[1], step[2], step[3]};
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] step);
		logic [4:0] s;
		case ({step[5:4], step[1:0]})
			4'b00_00: s = 5'd3;
			4'b00_01: s = 5'd7;
			4'b00_10: s = 5'd11;
			4'b00_11: s = 5'd19;
			4'b01_00: s = 5'd3;
			4'b01_01: s = 5'd5;
			4'b01_10: s = 5'd9;
			4'b01_11: s = 5'd13;
			4'b10_00: s = 5'd3;
			4'b10_01: s = 5'd9;
			4'b10_10: s = 5'd11;
			default:  s = 5'd15;
		endcase
		return s;
	endfunction

	function automatic word_t round_k(input logic [1:0] rnd);
		word_t k;
		case (rnd)
			2'd0:    k = 32'h00000000;
			2'd1:    k = 32'h5a827999;
			default: k = 32'h6ed9eba1;
		endcase
		return k;
	endfunction

	function automatic word_t bswap(input word_t w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

FILE: design/md4_buf.sv
module md4_buf (
	input  logic                 clk,
	input  logic                 we,
	input  logic [5:0]           waddr,
	input  logic [7:0]           wdata,
	input  logic [3:0]           raddr,
	output md4_pkg::word_t       rdata
);
	import md4_pkg::*;

	// 16 little-endian words, byte lane writes
	word_t mem [16];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[5:2]][{waddr[1:0], 3'b000} +: 8] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/md4_round.sv
module md4_round (
	input  md4_pkg::word_t a,
	input  md4_pkg::word_t b,
	input  md4_pkg::word_t c,
	input  md4_pkg::word_t d,
	input  md4_pkg::word_t x,
	input  logic [5:0]     step,
	output md4_pkg::word_t a_new
);
	import md4_pkg::*;

	word_t       f;
	word_t       sum;
	logic [63:0] rot;

	always_comb begin
		case (step[5:4])
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
	end

	assign sum   = a + f + x + round_k(step[5:4]);
	assign rot   = {sum, sum} << rot_amt(step);
	assign a_new = rot[63:32];

endmodule

FILE: design/md4_hash_engine.sv
// MD4 digest engine.
// Input channel (in_valid/in_ready): one beat is either a message byte
// (command 0, data_byte) or a finish (command 1). Output channel
// (out_valid/out_ready): one beat per finish, the 128-bit digest split into
// digest_high (bytes 0..7) and digest_low (bytes 8..15), byte 0 MSB.
// Data bytes are taken back to back while the engine is idle. The byte
// that completes a 64-byte block starts a compression on the single round
// unit (one word prefetch, 48 steps, one chaining add), during which no
// input is taken.
// A finish writes the padding and length bytes one per cycle (9 to 72)
// with one or two compressions; after the last one the digest is loaded
// into the output register and the engine re-initialises itself.
// The digest sits in an output register: data bytes for the next message
// are taken while it waits; a further finish waits until it is taken.
// Reset: chaining words go to the MD4 initial values, the bit count to zero,
// no output is pending.
module md4_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_high,
	output logic [63:0] digest_low
);
	import md4_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_LEN   = 3'd2;
	localparam logic [2:0] S_CPRE  = 3'd3;
	localparam logic [2:0] S_CSTEP = 3'd4;
	localparam logic [2:0] S_CFIN  = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  step_q;
	logic [63:0] bit_count_q;
	logic [63:0] len_q;
	logic        fin_q;
	logic        first_q;
	logic        last_q;
	logic        out_valid_q;
	logic [63:0] dig_hi_q;
	logic [63:0] dig_lo_q;
	word_t       h0_q, h1_q, h2_q, h3_q;
	word_t       ra_q, rb_q, rc_q, rd_q;

	logic        in_fire;
	logic        we;
	logic [7:0]  wdata;
	logic [5:0]  pos;
	logic [3:0]  raddr;
	word_t       xword;
	word_t       a_new;
	word_t       s0, s1, s2, s3;

	assign pos      = bit_count_q[8:3];
	assign in_ready = (state_q == S_IDLE) && !(command && out_valid_q);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		we    = 1'b0;
		wdata = data_byte;
		unique case (state_q)
			S_IDLE: we = in_fire && !command;
			S_PAD: begin
				we    = 1'b1;
				wdata = first_q ? 8'h80 : 8'h00;
			end
			S_LEN: begin
				we    = 1'b1;
				wdata = len_q[{pos[2:0], 3'b000} +: 8];
			end
			default: we = 1'b0;
		endcase
	end

	assign raddr = msg_idx((state_q == S_CSTEP) ? 6'(step_q + 6'd1) : 6'd0);

	md4_buf u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (pos),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (xword)
	);

	md4_round u_round (
		.a     (ra_q),
		.b     (rb_q),
		.c     (rc_q),
		.d     (rd_q),
		.x     (xword),
		.step  (step_q),
		.a_new (a_new)
	);

	assign s0 = h0_q + ra_q;
	assign s1 = h1_q + rb_q;
	assign s2 = h2_q + rc_q;
	assign s3 = h3_q + rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			bit_count_q <= '0;
			fin_q       <= 1'b0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			h0_q        <= IV_A;
			h1_q        <= IV_B;
			h2_q        <= IV_C;
			h3_q        <= IV_D;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (we) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && command) begin
						fin_q   <= 1'b1;
						first_q <= 1'b1;
						last_q  <= 1'b0;
						state_q <= S_PAD;
					end else if (in_fire && pos == 6'd63) begin
						state_q <= S_CPRE;
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					if (pos == 6'd63) begin
						state_q <= S_CPRE;
					end else if (pos == 6'd55) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					if (pos == 6'd63) begin
						last_q  <= 1'b1;
						state_q <= S_CPRE;
					end
				end
				S_CPRE: begin
					step_q  <= '0;
					state_q <= S_CSTEP;
				end
				S_CSTEP: begin
					step_q <= 6'(step_q + 6'd1);
					if (step_q == LAST_STEP) begin
						state_q <= S_CFIN;
					end
				end
				S_CFIN: begin
					if (fin_q && last_q) begin
						out_valid_q <= 1'b1;
						fin_q       <= 1'b0;
						last_q      <= 1'b0;
						bit_count_q <= '0;
						h0_q        <= IV_A;
						h1_q        <= IV_B;
						h2_q        <= IV_C;
						h3_q        <= IV_D;
						state_q     <= S_IDLE;
					end else begin
						h0_q    <= s0;
						h1_q    <= s1;
						h2_q    <= s2;
						h3_q    <= s3;
						state_q <= fin_q ? S_PAD : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire && command) begin
			len_q <= bit_count_q;
		end
		if (state_q == S_CPRE) begin
			ra_q <= h0_q;
			rb_q <= h1_q;
			rc_q <= h2_q;
			rd_q <= h3_q;
		end else if (state_q == S_CSTEP) begin
			ra_q <= rd_q;
			rb_q <= a_new;
			rc_q <= rb_q;
			rd_q <= rc_q;
		end
		if (state_q == S_CFIN && fin_q && last_q) begin
			dig_hi_q <= {bswap(s0), bswap(s1)};
			dig_lo_q <= {bswap(s2), bswap(s3)};
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_high = dig_hi_q;
	assign digest_low  = dig_lo_q;

	a_cpre_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CPRE |-> bit_count_q[8:3] == 6'd0)
		else $error("compression started on a partial block");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LEN |-> bit_count_q[8:6] == 3'b111)
		else $error("length beat outside the last eight bytes");

	a_step_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CSTEP && step_q == LAST_STEP |=> state_q == S_CFIN)
		else $error("round sequence overran");

	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> bit_count_q == 64'd0 && h0_q == IV_A && h3_q == IV_D
			&& state_q == S_IDLE)
		else $error("engine not re-initialised after digest");

	a_finish_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && command |-> !out_valid_q)
		else $error("finish accepted while a digest is pending");

endmodule
